@@ rtl/ntc_pkg.sv @@
// Shared types, type codes and constants of the numeric type converter.
package ntc_pkg;

	localparam int NUM_POINTS = 8;
	localparam int IDX_W = 3;
	localparam int CNT_W = 4;
	localparam int MAP_W = 24;
	localparam int CODE_W = 3;
	localparam int WORD_W = 32;
	localparam int VAL_W = 35;
	localparam logic [15:0] HALF_MASK = 16'hFFFF;

	localparam logic [CODE_W-1:0] TYPE_U16 = 3'd0;
	localparam logic [CODE_W-1:0] TYPE_I16 = 3'd1;
	localparam logic [CODE_W-1:0] TYPE_U32 = 3'd2;
	localparam logic [CODE_W-1:0] TYPE_I32 = 3'd3;
	localparam logic [CODE_W-1:0] TYPE_F32 = 3'd4;

	localparam logic [1:0] REG_NUM_POINTS = 2'd0;
	localparam logic [1:0] REG_SOURCE_MAP = 2'd1;
	localparam logic [1:0] REG_TARGET_MAP = 2'd2;

	typedef struct packed {
		logic [CODE_W-1:0] src;
		logic [CODE_W-1:0] tgt;
	} conv_ctl_t;

endpackage

@@ rtl/ntc_convert.sv @@
// Combinational conversion of one word between the supported numeric types.
module ntc_convert (
	input  ntc_pkg::conv_ctl_t             ctl,
	input  logic [ntc_pkg::WORD_W-1:0]     word,
	output logic [ntc_pkg::WORD_W-1:0]     result
);

	logic               sgn;
	logic [7:0]         ex;
	logic [23:0]        man;
	logic               nan_src;
	logic [33:0]        fmag;
	logic signed [ntc_pkg::VAL_W-1:0] v;
	logic               vneg;
	logic [33:0]        mag;
	logic [5:0]         p;
	logic [33:0]        norm;
	logic [23:0]        keep;
	logic               guard;
	logic               sticky;
	logic [24:0]        rnd;
	logic [7:0]         fexp;
	logic [22:0]        ffrac;

	always_comb begin
		sgn = word[31];
		ex = word[30:23];
		man = {1'b1, word[22:0]};
		nan_src = 1'b0;
		fmag = '0;
		if (ex == 8'hFF) begin
			nan_src = (word[22:0] != '0);
			fmag = 34'h2_0000_0000;
		end else if (ex < 8'd127) begin
			fmag = '0;
		end else if (ex >= 8'd160) begin
			fmag = 34'h2_0000_0000;
		end else if (ex >= 8'd150) begin
			fmag = {10'd0, man} << (ex - 8'd150);
		end else begin
			fmag = {10'd0, man} >> (8'd150 - ex);
		end

		case (ctl.src)
			ntc_pkg::TYPE_U16: v = {19'd0, word[15:0]};
			ntc_pkg::TYPE_I16: v = {{19{word[15]}}, word[15:0]};
			ntc_pkg::TYPE_U32: v = {3'd0, word};
			ntc_pkg::TYPE_I32: v = {{3{word[31]}}, word};
			default: v = sgn ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
		endcase

		vneg = v[ntc_pkg::VAL_W-1];
		mag = vneg ? 34'(-v) : v[33:0];
		p = '0;
		for (int i = 0; i < 34; i++) begin
			if (mag[i]) p = 6'(i);
		end
		// Normalise so that the leading one sits at bit 33.
		norm = mag << (6'd33 - p);
		keep = norm[33:10];
		guard = norm[9];
		sticky = (norm[8:0] != '0);
		rnd = {1'b0, keep} + 25'(guard && (sticky || keep[0]));
		if (rnd[24]) begin
			fexp = 8'(p) + 8'd128;
			ffrac = rnd[23:1];
		end else begin
			fexp = 8'(p) + 8'd127;
			ffrac = rnd[22:0];
		end

		if (ctl.src == ntc_pkg::TYPE_F32 && ctl.tgt == ntc_pkg::TYPE_F32) begin
			result = word;
		end else if (ctl.src == ntc_pkg::TYPE_F32 && nan_src) begin
			result = '0;
		end else begin
			case (ctl.tgt)
				ntc_pkg::TYPE_U16: begin
					if (vneg) result = '0;
					else if (v > 35'sd65535) result = {16'd0, ntc_pkg::HALF_MASK};
					else result = {16'd0, v[15:0]};
				end
				ntc_pkg::TYPE_I16: begin
					if (v < -35'sd32768) result = 32'h0000_8000;
					else if (v > 35'sd32767) result = 32'h0000_7FFF;
					else result = {16'd0, v[15:0]};
				end
				ntc_pkg::TYPE_U32: begin
					if (vneg) result = '0;
					else if (v[34:32] != '0) result = 32'hFFFF_FFFF;
					else result = v[31:0];
				end
				ntc_pkg::TYPE_I32: begin
					if (v < -35'sd2147483648) result = 32'h8000_0000;
					else if (v > 35'sd2147483647) result = 32'h7FFF_FFFF;
					else result = v[31:0];
				end
				default: result = (mag == '0) ? '0 : {vneg, fexp, ffrac};
			endcase
		end
	end

endmodule

@@ rtl/numeric_type_converter_top.sv @@
// Top level of the numeric type converter: configuration, input and result registers.
// Each input goes through the input register, the converter and the result register.
// Throughput: one item per cycle; the input register and the result register
// both advance together whenever the result side is not stalled.
// Reset clears the configuration registers and the valid flags; payloads are not reset.
module numeric_type_converter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [ntc_pkg::MAP_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ntc_pkg::IDX_W-1:0]       point_index,
	input  logic [ntc_pkg::WORD_W-1:0]      raw_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ntc_pkg::IDX_W-1:0]       result_index,
	output logic [ntc_pkg::WORD_W-1:0]      converted_word
);

	logic [ntc_pkg::CNT_W-1:0]  num_points_q;
	logic [ntc_pkg::MAP_W-1:0]  src_map_q;
	logic [ntc_pkg::MAP_W-1:0]  tgt_map_q;
	logic                       valid_s1;
	logic [ntc_pkg::IDX_W-1:0]  idx_s1;
	logic [ntc_pkg::WORD_W-1:0] word_s1;
	ntc_pkg::conv_ctl_t         ctl;
	logic                       keep_item;
	logic [ntc_pkg::WORD_W-1:0] conv;
	logic                       adv;
	logic                       valid_s2;
	logic [ntc_pkg::IDX_W-1:0]  idx_s2;
	logic [ntc_pkg::WORD_W-1:0] word_s2;

	assign cfg_ready = 1'b1;
	assign adv = !(valid_s2 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= '0;
			src_map_q <= '0;
			tgt_map_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ntc_pkg::REG_NUM_POINTS: num_points_q <= cfg_data[ntc_pkg::CNT_W-1:0];
				ntc_pkg::REG_SOURCE_MAP: src_map_q <= cfg_data;
				ntc_pkg::REG_TARGET_MAP: tgt_map_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && keep_item;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= point_index;
			word_s1 <= raw_word;
			idx_s2 <= idx_s1;
			word_s2 <= conv;
		end
	end

	always_comb begin
		ctl.src = src_map_q[idx_s1*3 +: 3];
		ctl.tgt = tgt_map_q[idx_s1*3 +: 3];
		keep_item = ({1'b0, idx_s1} < num_points_q) && (ctl.src <= ntc_pkg::TYPE_F32)
			&& (ctl.tgt <= ntc_pkg::TYPE_F32);
	end

	ntc_convert u_convert (
		.ctl    (ctl),
		.word   (word_s1),
		.result (conv)
	);

	assign out_valid = valid_s2;
	assign result_index = idx_s2;
	assign converted_word = word_s2;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(word_s2) && $stable(idx_s2))
		else $error("result changed while stalled");
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled with empty result register");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && ({1'b0, idx_s1} >= num_points_q) |=> !valid_s2)
		else $error("out of range index produced a result");

endmodule
